>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define WIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WIA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/wia_pkg.sv
package wia_pkg;

  localparam int DIV_BITS = 64;
  localparam int LANES    = 4;

  localparam logic [63:0] ALL_ONES64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] POS_LIMIT64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT64 = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_NEG  = 3'd2,
    FN_MUL  = 3'd3,
    FN_UDIV = 3'd4,
    FN_SDIV = 3'd5
  } func_t;

  // Per-item control and early result, carried down the pipe
  typedef struct packed {
    func_t       func;
    logic [1:0]  wc;
    logic        sg;
    logic        ok;
    logic        ylo_pos;
    logic [3:0]  mneg;
    logic [3:0]  qneg;
    logic [63:0] rb;
    logic [63:0] rs;
  } meta_t;

  // One restoring divider lane: partial remainder, dividend/quotient, divisor
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
  } div_lane_t;

  function automatic logic [63:0] mask_of(input logic [1:0] wc);
    logic [63:0] m;
    unique case (wc)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = ALL_ONES64;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] half_of(input logic [1:0] wc);
    logic [63:0] h;
    unique case (wc)
      2'd0:    h = 64'h0000_0000_0000_0080;
      2'd1:    h = 64'h0000_0000_0000_8000;
      2'd2:    h = 64'h0000_0000_8000_0000;
      default: h = NEG_LIMIT64;
    endcase
    return h;
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [63:0] m,
                                       input logic [63:0] h);
    return ((v & h) != 64'd0) ? (v | ~m) : v;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] mx);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, mx}) ? mx : s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] smin(input logic [63:0] a, input logic [63:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  function automatic div_lane_t div_step(input div_lane_t x);
    logic [64:0] r2;
    logic        ge;
    div_lane_t   o;
    r2    = {x.rem, x.num[63]};
    ge    = r2 >= {1'b0, x.den};
    o.den = x.den;
    o.num = {x.num[62:0], ge};
    o.rem = ge ? 64'(r2 - {1'b0, x.den}) : r2[63:0];
    return o;
  endfunction

endpackage

>>> src/wia_div_chain.sv
// Four restoring dividers, one quotient bit per stage, with item control alongside.
module wia_div_chain (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    ce,
  input  logic                                    in_vld,
  input  wia_pkg::meta_t                          in_meta,
  input  wia_pkg::div_lane_t [wia_pkg::LANES-1:0] in_lane,
  output logic                                    out_vld,
  output wia_pkg::meta_t                          out_meta,
  output wia_pkg::div_lane_t [wia_pkg::LANES-1:0] out_lane
);

  logic [wia_pkg::DIV_BITS-1:0]            vld;
  wia_pkg::meta_t                          meta [wia_pkg::DIV_BITS];
  wia_pkg::div_lane_t [wia_pkg::LANES-1:0] lane [wia_pkg::DIV_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[wia_pkg::DIV_BITS-2:0], in_vld};
    end
  end

  for (genvar s = 0; s < wia_pkg::DIV_BITS; s++) begin : g_st
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ce) begin
          meta[0] <= in_meta;
          for (int k = 0; k < wia_pkg::LANES; k++) begin
            lane[0][k] <= wia_pkg::div_step(in_lane[k]);
          end
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (ce) begin
          meta[s] <= meta[s-1];
          for (int k = 0; k < wia_pkg::LANES; k++) begin
            lane[s][k] <= wia_pkg::div_step(lane[s-1][k]);
          end
        end
      end
    end
  end

  assign out_vld  = vld[wia_pkg::DIV_BITS-1];
  assign out_meta = meta[wia_pkg::DIV_BITS-1];
  assign out_lane = lane[wia_pkg::DIV_BITS-1];

endmodule

>>> src/wrapped_interval_arith_unit_top.sv
// Wrapped interval arithmetic unit. Each input transfer carries two intervals
// (base bit pattern plus span) at 8, 16, 32 or 64 bits, an opcode (add, sub,
// neg, mult, unsigned div, signed div) and a signedness flag; each produces
// exactly one output transfer with the result interval and a valid flag
// (cleared on possible divide by zero, signed MIN/-1, signedness mismatch or
// an unused opcode, with base and span then zero). The unit is fully
// pipelined: it takes one transfer per cycle while the output is not stalled.
// The 64-stage restoring divider (one quotient bit per stage) follows 10
// stages of operand preparation and a 64x64 multiplier built from 32x32
// partial products; three stages after the divider form the quotient limits
// and the output register. A stalled output freezes the whole pipe, so
// s_axis_tready follows m_axis_tready whenever a result is waiting.
module wrapped_interval_arith_unit_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // a_base, a_span, b_base, b_span
  input  logic [5:0]   s_axis_tuser,  // func[2:0], width_code[4:3], is_signed_mode[5]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // res_base, res_span
  output logic [0:0]   m_axis_tuser   // res_valid
);

  localparam int MUL_LAT = 7;  // stages D..J

  typedef struct packed {
    wia_pkg::func_t func;
    logic [1:0]     wc;
    logic           sg;
    logic [63:0]    ab;
    logic [63:0]    as;
    logic [63:0]    bb;
    logic [63:0]    bs;
  } in_t;

  typedef struct packed {
    wia_pkg::func_t func;
    logic [1:0]     wc;
    logic           sg;
    logic [63:0]    rb;
    logic [63:0]    rs;
    logic [63:0]    ab;
    logic [63:0]    as;
    logic [63:0]    bb;
    logic [63:0]    bs;
    logic [63:0]    amin;
    logic [63:0]    amax;
    logic [63:0]    bmin;
    logic [63:0]    bmax;
    logic [63:0]    xlo;
    logic [63:0]    xhi;
    logic [63:0]    ylo;
    logic [63:0]    yhi;
  } prep_t;

  // Global advance: the whole pipe moves unless the output holds a result not taken
  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // ---------------- stage A: mask bases, clip spans ----------------
  in_t         sa, sa_next;
  logic        v_a;
  logic [63:0] m_in;

  always_comb begin
    m_in         = wia_pkg::mask_of(s_axis_tuser[4:3]);
    sa_next.func = wia_pkg::func_t'(s_axis_tuser[2:0]);
    sa_next.wc   = s_axis_tuser[4:3];
    sa_next.sg   = s_axis_tuser[5];
    sa_next.ab   = s_axis_tdata[63:0] & m_in;
    sa_next.as   = (s_axis_tdata[127:64] > m_in) ? m_in : s_axis_tdata[127:64];
    sa_next.bb   = s_axis_tdata[191:128] & m_in;
    sa_next.bs   = (s_axis_tdata[255:192] > m_in) ? m_in : s_axis_tdata[255:192];
  end

  // ---------------- stage B: unsigned/signed limits, add/sub/neg ----------------
  prep_t       pb, pb_next;
  logic        v_b;
  logic [63:0] mb, hb;
  logic        awrap, bwrap, across, bcross;

  always_comb begin
    mb     = wia_pkg::mask_of(sa.wc);
    hb     = wia_pkg::half_of(sa.wc);
    awrap  = ({1'b0, sa.ab} + {1'b0, sa.as}) > {1'b0, mb};
    bwrap  = ({1'b0, sa.bb} + {1'b0, sa.bs}) > {1'b0, mb};
    across = ({1'b0, sa.ab ^ hb} + {1'b0, sa.as}) > {1'b0, mb};
    bcross = ({1'b0, sa.bb ^ hb} + {1'b0, sa.bs}) > {1'b0, mb};

    pb_next.func = sa.func;
    pb_next.wc   = sa.wc;
    pb_next.sg   = sa.sg;
    pb_next.ab   = sa.ab;
    pb_next.as   = sa.as;
    pb_next.bb   = sa.bb;
    pb_next.bs   = sa.bs;
    pb_next.amin = awrap ? 64'd0 : sa.ab;
    pb_next.amax = wia_pkg::sat_add(sa.ab, sa.as, mb);
    pb_next.bmin = bwrap ? 64'd0 : sa.bb;
    pb_next.bmax = wia_pkg::sat_add(sa.bb, sa.bs, mb);
    // crossing the signed wrap point widens to the full signed range
    pb_next.xlo  = across ? (64'd0 - hb) : wia_pkg::sext(sa.ab, mb, hb);
    pb_next.xhi  = across ? (hb - 64'd1) : wia_pkg::sext((sa.ab + sa.as) & mb, mb, hb);
    pb_next.ylo  = bcross ? (64'd0 - hb) : wia_pkg::sext(sa.bb, mb, hb);
    pb_next.yhi  = bcross ? (hb - 64'd1) : wia_pkg::sext((sa.bb + sa.bs) & mb, mb, hb);

    unique case (sa.func)
      wia_pkg::FN_ADD: begin
        pb_next.rb = (sa.ab + sa.bb) & mb;
        pb_next.rs = wia_pkg::sat_add(sa.as, sa.bs, mb);
      end
      wia_pkg::FN_SUB: begin
        pb_next.rb = (sa.ab - sa.bb) & mb;
        pb_next.rs = wia_pkg::sat_add(sa.as, sa.bs, mb);
      end
      wia_pkg::FN_NEG: begin
        pb_next.rb = (64'd0 - sa.ab) & mb;
        pb_next.rs = sa.as;
      end
      default: begin
        pb_next.rb = 64'd0;
        pb_next.rs = 64'd0;
      end
    endcase
  end

  // ---------------- stage C: validity, multiplier and divider operands ----------------
  wia_pkg::meta_t                          meta_c, meta_c_next;
  logic [3:0][63:0]                        mop_a, mop_a_next, mop_b, mop_b_next;
  wia_pkg::div_lane_t [wia_pkg::LANES-1:0] lane_c, lane_c_next;
  logic                                    v_c;
  logic [63:0]                             hc, xlo_m, xhi_m, ylo_m, yhi_m;
  logic                                    sdiv_bad;

  always_comb begin
    hc       = wia_pkg::half_of(pb.wc);
    xlo_m    = wia_pkg::mag(pb.xlo);
    xhi_m    = wia_pkg::mag(pb.xhi);
    ylo_m    = wia_pkg::mag(pb.ylo);
    yhi_m    = wia_pkg::mag(pb.yhi);
    // divisor range holds zero, or holds -1 while the dividend reaches the minimum
    sdiv_bad = ($signed(pb.ylo) <= 64'sd0 && $signed(pb.yhi) >= 64'sd0) ||
               ($signed(pb.ylo) <= -64'sd1 && $signed(pb.yhi) >= -64'sd1 &&
                $signed(pb.xlo) <= $signed(64'd0 - hc));

    meta_c_next.func    = pb.func;
    meta_c_next.wc      = pb.wc;
    meta_c_next.sg      = pb.sg;
    meta_c_next.ylo_pos = $signed(pb.ylo) > 64'sd0;
    meta_c_next.rb      = pb.rb;
    meta_c_next.rs      = pb.rs;
    unique case (pb.func)
      wia_pkg::FN_ADD, wia_pkg::FN_SUB, wia_pkg::FN_NEG, wia_pkg::FN_MUL:
        meta_c_next.ok = 1'b1;
      wia_pkg::FN_UDIV:
        meta_c_next.ok = !pb.sg && (pb.bmin != 64'd0) && (pb.bmax != 64'd0);
      wia_pkg::FN_SDIV:
        meta_c_next.ok = pb.sg && !sdiv_bad;
      default:
        meta_c_next.ok = 1'b0;
    endcase

    if (!pb.sg) begin
      // span expansion: ab*bs, bb*as, as*bs, and ab*bb for the base
      mop_a_next       = {pb.ab, pb.as, pb.bb, pb.ab};
      mop_b_next       = {pb.bb, pb.bs, pb.as, pb.bs};
      meta_c_next.mneg = 4'b0000;
    end else begin
      // corners: lo*lo, hi*hi, lo*hi, hi*lo
      mop_a_next       = {xhi_m, xlo_m, xhi_m, xlo_m};
      mop_b_next       = {ylo_m, yhi_m, yhi_m, ylo_m};
      meta_c_next.mneg = {pb.xhi[63] ^ pb.ylo[63], pb.xlo[63] ^ pb.yhi[63],
                          pb.xhi[63] ^ pb.yhi[63], pb.xlo[63] ^ pb.ylo[63]};
    end

    // lanes: xhi/ylo, xhi/yhi, xlo/ylo, xlo/yhi
    lane_c_next[0]   = '{rem: 64'd0, num: xhi_m, den: ylo_m};
    lane_c_next[1]   = '{rem: 64'd0, num: xhi_m, den: yhi_m};
    lane_c_next[2]   = '{rem: 64'd0, num: xlo_m, den: ylo_m};
    lane_c_next[3]   = '{rem: 64'd0, num: xlo_m, den: yhi_m};
    meta_c_next.qneg = {pb.xlo[63] ^ pb.yhi[63], pb.xlo[63] ^ pb.ylo[63],
                        pb.xhi[63] ^ pb.yhi[63], pb.xhi[63] ^ pb.ylo[63]};
    if (pb.func == wia_pkg::FN_UDIV) begin
      // unsigned quotients keep their sign
      lane_c_next[0]   = '{rem: 64'd0, num: pb.amin, den: pb.bmax};
      lane_c_next[1]   = '{rem: 64'd0, num: pb.amax, den: pb.bmin};
      meta_c_next.qneg = 4'b0000;
    end
  end

  // ---------------- stages D..J: multiplier ----------------
  wia_pkg::meta_t                          meta_dl [MUL_LAT];
  wia_pkg::div_lane_t [wia_pkg::LANES-1:0] lane_dl [MUL_LAT];
  logic [MUL_LAT-1:0]                      v_dl;
  wia_pkg::meta_t                          meta_j_next;

  logic [3:0][3:0][63:0] pp;        // D: 32x32 partial products
  logic [3:0][63:0]      ll, hh;    // E
  logic [3:0][64:0]      mid;       // E
  logic [3:0][127:0]     prod;      // F: full products
  logic [3:0][63:0]      sv;        // G: saturated products
  logic [3:0][63:0]      hs;        // H: first combine
  logic [63:0]           i0, i1;    // I: result limits or unsigned result
  logic [63:0]           mi, mj, dj;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        pp[k][0] <= {32'd0, mop_a[k][31:0]}  * {32'd0, mop_b[k][31:0]};
        pp[k][1] <= {32'd0, mop_a[k][31:0]}  * {32'd0, mop_b[k][63:32]};
        pp[k][2] <= {32'd0, mop_a[k][63:32]} * {32'd0, mop_b[k][31:0]};
        pp[k][3] <= {32'd0, mop_a[k][63:32]} * {32'd0, mop_b[k][63:32]};
        ll[k]    <= pp[k][0];
        hh[k]    <= pp[k][3];
        mid[k]   <= {1'b0, pp[k][1]} + {1'b0, pp[k][2]};
        prod[k]  <= {hh[k], ll[k]} + ({63'd0, mid[k]} << 32);
        // G: saturate (meta_dl[2] belongs to the item in F)
        if (!meta_dl[2].sg) begin
          if (k == 3) begin
            sv[k] <= prod[k][63:0];
          end else begin
            sv[k] <= (prod[k][127:64] != 64'd0) ? wia_pkg::ALL_ONES64 : prod[k][63:0];
          end
        end else if (meta_dl[2].mneg[k]) begin
          sv[k] <= (prod[k] > {64'd0, wia_pkg::NEG_LIMIT64}) ? wia_pkg::NEG_LIMIT64 :
                   (64'd0 - prod[k][63:0]);
        end else begin
          sv[k] <= (prod[k] > {64'd0, wia_pkg::POS_LIMIT64}) ? wia_pkg::POS_LIMIT64 :
                   prod[k][63:0];
        end
      end
      // H
      if (!meta_dl[3].sg) begin
        hs[0] <= wia_pkg::sat_add(sv[0], sv[1], wia_pkg::ALL_ONES64);
        hs[1] <= sv[2];
        hs[2] <= sv[3];
        hs[3] <= 64'd0;
      end else begin
        hs[0] <= wia_pkg::smin(sv[0], sv[1]);
        hs[1] <= wia_pkg::smax(sv[0], sv[1]);
        hs[2] <= wia_pkg::smin(sv[2], sv[3]);
        hs[3] <= wia_pkg::smax(sv[2], sv[3]);
      end
      // I
      if (!meta_dl[4].sg) begin
        i0 <= hs[2] & mi;
        i1 <= (wia_pkg::sat_add(hs[0], hs[1], wia_pkg::ALL_ONES64) > mi) ? mi :
              wia_pkg::sat_add(hs[0], hs[1], wia_pkg::ALL_ONES64);
      end else begin
        i0 <= wia_pkg::smin(hs[0], hs[2]);
        i1 <= wia_pkg::smax(hs[1], hs[3]);
      end
    end
  end

  always_comb begin
    mi          = wia_pkg::mask_of(meta_dl[4].wc);
    mj          = wia_pkg::mask_of(meta_dl[5].wc);
    dj          = i1 - i0;
    meta_j_next = meta_dl[5];
    if (meta_dl[5].func == wia_pkg::FN_MUL) begin
      if (meta_dl[5].sg) begin
        meta_j_next.rb = i0 & mj;
        meta_j_next.rs = (dj > mj) ? mj : dj;
      end else begin
        meta_j_next.rb = i0;
        meta_j_next.rs = i1;
      end
    end
  end

  // ---------------- divider: 64 stages ----------------
  logic                                    v_q;
  wia_pkg::meta_t                          meta_q;
  wia_pkg::div_lane_t [wia_pkg::LANES-1:0] lane_q;

  wia_div_chain u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (v_dl[MUL_LAT-1]),
    .in_meta  (meta_dl[MUL_LAT-1]),
    .in_lane  (lane_dl[MUL_LAT-1]),
    .out_vld  (v_q),
    .out_meta (meta_q),
    .out_lane (lane_q)
  );

  // ---------------- P1: signed quotients, P2: limits, output register ----------------
  wia_pkg::meta_t   meta_p1, meta_p2;
  logic [3:0][63:0] q;
  logic [63:0]      lo, hi, mo, dq;
  logic             v_p1, v_p2, v_out;
  logic [63:0]      res_base, res_span, res_base_next, res_span_next;
  logic             res_valid, res_valid_next;

  always_comb begin
    mo             = wia_pkg::mask_of(meta_p2.wc);
    dq             = hi - lo;
    res_valid_next = meta_p2.ok;
    unique case (meta_p2.func)
      wia_pkg::FN_UDIV: begin
        res_base_next = lo;
        res_span_next = dq;
      end
      wia_pkg::FN_SDIV: begin
        res_base_next = lo & mo;
        res_span_next = (dq > mo) ? mo : dq;
      end
      default: begin
        res_base_next = meta_p2.rb;
        res_span_next = meta_p2.rs;
      end
    endcase
    if (!meta_p2.ok) begin
      res_base_next = 64'd0;
      res_span_next = 64'd0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ce) begin
      sa     <= sa_next;
      pb     <= pb_next;
      meta_c <= meta_c_next;
      mop_a  <= mop_a_next;
      mop_b  <= mop_b_next;
      lane_c <= lane_c_next;

      meta_dl[0] <= meta_c;
      lane_dl[0] <= lane_c;
      for (int i = 1; i < MUL_LAT; i++) begin
        lane_dl[i] <= lane_dl[i-1];
      end
      for (int i = 1; i < MUL_LAT - 1; i++) begin
        meta_dl[i] <= meta_dl[i-1];
      end
      meta_dl[MUL_LAT-1] <= meta_j_next;

      meta_p1 <= meta_q;
      for (int k = 0; k < wia_pkg::LANES; k++) begin
        q[k] <= meta_q.qneg[k] ? (64'd0 - lane_q[k].num) : lane_q[k].num;
      end

      meta_p2 <= meta_p1;
      if (meta_p1.func == wia_pkg::FN_UDIV) begin
        lo <= q[0];
        hi <= q[1];
      end else if (meta_p1.ylo_pos) begin
        hi <= wia_pkg::smax(q[0], q[1]);
        lo <= wia_pkg::smin(q[2], q[3]);
      end else begin
        hi <= wia_pkg::smax(q[2], q[3]);
        lo <= wia_pkg::smin(q[0], q[1]);
      end

      res_base  <= res_base_next;
      res_span  <= res_span_next;
      res_valid <= res_valid_next;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a   <= 1'b0;
      v_b   <= 1'b0;
      v_c   <= 1'b0;
      v_dl  <= '0;
      v_p1  <= 1'b0;
      v_p2  <= 1'b0;
      v_out <= 1'b0;
    end else if (ce) begin
      v_a   <= s_axis_tvalid;
      v_b   <= v_a;
      v_c   <= v_b;
      v_dl  <= {v_dl[MUL_LAT-2:0], v_c};
      v_p1  <= v_q;
      v_p2  <= v_p1;
      v_out <= v_p2;
    end
  end

  assign m_axis_tvalid   = v_out;
  assign m_axis_tdata    = {res_span, res_base};
  assign m_axis_tuser[0] = res_valid;

endmodule

>>> src/wia_chk.sv
`include "assert_macros.svh"

// Port-level checks of the wrapped interval unit.
module wia_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  `WIA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `WIA_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result changed")
  `WIA_ASSERT(a_invalid_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 128'd0, "invalid result carries data")
  `WIA_ASSERT(a_ready_only_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
  `WIA_ASSERT_ALL(a_reset_empty, rst |=> !m_axis_tvalid, "result present after reset")

endmodule

bind wrapped_interval_arith_unit_top wia_chk u_wia_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_wrapped_interval_arith_unit_top.sv
module tb_wrapped_interval_arith_unit_top;

  typedef struct {
    logic [63:0] base;
    logic [63:0] span;
    logic        ok;
  } ival_res_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } slim_t;

  // Golden model of the interval unit, one result per operation
  class interval_scoreboard;
    ival_res_t pending[$];
    int        errors;

    static function logic [63:0] usat(logic [63:0] a, logic [63:0] b, logic [63:0] mx);
      return (mx - a < b) ? mx : a + b;
    endfunction

    static function logic [63:0] umul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return (p[127:64] != 0) ? wia_pkg::ALL_ONES64 : p[63:0];
    endfunction

    static function logic signed [63:0] smul_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      if (p > 128'(signed'(wia_pkg::POS_LIMIT64))) return wia_pkg::POS_LIMIT64;
      if (p < -128'sh8000_0000_0000_0000) return wia_pkg::NEG_LIMIT64;
      return p[63:0];
    endfunction

    static function logic [63:0] sx(logic [63:0] v, logic [63:0] m, logic [63:0] h);
      v = v & m;
      return ((v & h) != 0) ? (v | ~m) : v;
    endfunction

    static function slim_t slimits(logic [63:0] b, logic [63:0] s,
                                   logic [63:0] m, logic [63:0] h);
      slim_t r;
      if (m - s < (b ^ h)) begin
        r.lo = sx(h, m, h);
        r.hi = sx(h - 1, m, h);
      end else begin
        r.lo = sx(b, m, h);
        r.hi = sx(b + s, m, h);
      end
      return r;
    endfunction

    static function logic signed [63:0] smn(logic signed [63:0] a, logic signed [63:0] b);
      return a < b ? a : b;
    endfunction

    static function logic signed [63:0] smx(logic signed [63:0] a, logic signed [63:0] b);
      return a > b ? a : b;
    endfunction

    static function ival_res_t build(logic [63:0] lo, logic [63:0] hi, logic [63:0] m);
      ival_res_t r;
      r.base = lo & m;
      r.span = (hi - lo > m) ? m : hi - lo;
      r.ok   = 1;
      return r;
    endfunction

    function void note_input(logic [2:0] fn, logic [1:0] wc, logic sg,
                             logic [63:0] ab0, logic [63:0] as0,
                             logic [63:0] bb0, logic [63:0] bs0);
      logic [63:0] m, h, ab, as_, bb, bs, e, f, g, t, amin, amax, bmin, bmax;
      logic signed [63:0] p0, p1, p2, p3, lo, hi, hmin;
      slim_t x, y;
      ival_res_t r;
      m = (wc == 3) ? wia_pkg::ALL_ONES64 : ((64'd1 << (8 << wc)) - 1);
      h = 64'd1 << ((8 << wc) - 1);
      ab = ab0 & m; bb = bb0 & m;
      as_ = as0 > m ? m : as0;
      bs = bs0 > m ? m : bs0;
      r = '{64'd0, 64'd0, 1'b1};
      case (fn)
        wia_pkg::FN_ADD: begin
          r.base = (ab + bb) & m;
          r.span = usat(as_, bs, m);
        end
        wia_pkg::FN_SUB: begin
          r.base = (ab - bb) & m;
          r.span = usat(as_, bs, m);
        end
        wia_pkg::FN_NEG: begin
          r.base = (64'd0 - ab) & m;
          r.span = as_;
        end
        wia_pkg::FN_MUL: begin
          if (!sg) begin
            e = umul_sat(ab, bs);
            f = umul_sat(bb, as_);
            g = umul_sat(as_, bs);
            t = usat(usat(e, f, wia_pkg::ALL_ONES64), g, wia_pkg::ALL_ONES64);
            r.span = t > m ? m : t;
            r.base = (ab * bb) & m;
          end else begin
            x = slimits(ab, as_, m, h);
            y = slimits(bb, bs, m, h);
            p0 = smul_sat(x.lo, y.lo);
            p1 = smul_sat(x.hi, y.hi);
            p2 = smul_sat(x.lo, y.hi);
            p3 = smul_sat(x.hi, y.lo);
            r = build(smn(smn(p0, p1), smn(p2, p3)), smx(smx(p0, p1), smx(p2, p3)), m);
          end
        end
        wia_pkg::FN_UDIV: begin
          amin = (m - as_ < ab) ? 64'd0 : ab;
          amax = usat(ab, as_, m);
          bmin = (m - bs < bb) ? 64'd0 : bb;
          bmax = usat(bb, bs, m);
          if (sg || bmin == 0 || bmax == 0) r.ok = 0;
          else begin
            r.base = amin / bmax;
            r.span = amax / bmin - r.base;
          end
        end
        wia_pkg::FN_SDIV: begin
          x = slimits(ab, as_, m, h);
          y = slimits(bb, bs, m, h);
          hmin = sx(h, m, h);
          if (!sg || ($signed(y.lo) <= 0 && $signed(y.hi) >= 0) ||
              ($signed(y.lo) <= -1 && $signed(y.hi) >= -1 && $signed(x.lo) <= hmin))
            r.ok = 0;
          else if ($signed(y.lo) > 0) begin
            hi = smx($signed(x.hi) / $signed(y.lo), $signed(x.hi) / $signed(y.hi));
            lo = smn($signed(x.lo) / $signed(y.lo), $signed(x.lo) / $signed(y.hi));
            r = build(lo, hi, m);
          end else begin
            hi = smx($signed(x.lo) / $signed(y.lo), $signed(x.lo) / $signed(y.hi));
            lo = smn($signed(x.hi) / $signed(y.lo), $signed(x.hi) / $signed(y.hi));
            r = build(lo, hi, m);
          end
        end
        default: r.ok = 0;
      endcase
      if (!r.ok) begin
        r.base = 0;
        r.span = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] base, logic [63:0] span, logic ok);
      ival_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result base=%h span=%h valid=%b", $realtime, base, span, ok);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.base !== base || e.span !== span || e.ok !== ok) begin
        $display("%0t: mismatch exp base=%h span=%h valid=%b act base=%h span=%h valid=%b",
                 $realtime, e.base, e.span, e.ok, base, span, ok);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;  // a_base, a_span, b_base, b_span
  logic [5:0]   s_axis_tuser = '0;  // func, width_code, is_signed_mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [127:0] m_axis_tdata;       // res_base, res_span
  logic [0:0]   m_axis_tuser;       // res_valid

  interval_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  wrapped_interval_arith_unit_top DUT (.*);

  // Compare every output transfer as it happens
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser[0]);

  // Receiver backpressure, changed on the falling edge
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Interesting operand values: zero, one, all ones, the 8-bit signed edges and random values
  function automatic logic [63:0] pick_val();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = 64'd0;
      1: v = 64'd1;
      2: v = wia_pkg::ALL_ONES64;
      3: v = 64'h7F;
      4: v = 64'h80;
      5: v = 64'hFFFF_FFFF_FFFF_FF80;
      6: v = {$urandom, $urandom} >> $urandom_range(63);
      7: v = 64'($urandom_range(16));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Drive one transfer; held until accepted, note it in the scoreboard at the edge.
  // Returns at the falling edge after the transfer; the next call or drain() sets tvalid.
  task automatic send_item(logic [2:0] fn, logic [1:0] wc, logic sg,
                           logic [63:0] ab, logic [63:0] as_, logic [63:0] bb,
                           logic [63:0] bs);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {bs, bb, as_, ab};
    s_axis_tuser  <= {sg, wc, fn};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(fn, wc, sg, ab, as_, bb, bs);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [2:0] fn;
    fn = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    // Signedness usually matched to the divide flavor so division reaches the math
    send_item(fn, 2'($urandom_range(3)),
              (fn == wia_pkg::FN_UDIV) ? ($urandom_range(9) == 0) :
              (fn == wia_pkg::FN_SDIV) ? ($urandom_range(9) != 0) :
              1'($urandom_range(1)),
              pick_val(), ($urandom_range(2) == 0) ? pick_val() : 64'($urandom_range(3)),
              pick_val(), ($urandom_range(2) == 0) ? pick_val() : 64'($urandom_range(3)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed corners: all ops, each width, saturation, div by zero, MIN/-1, mismatch
    send_item(wia_pkg::FN_ADD, 0, 0, 64'hFF, 64'hFF, 64'h1, 64'h1);
    send_item(wia_pkg::FN_ADD, 3, 0, wia_pkg::ALL_ONES64, wia_pkg::ALL_ONES64,
              wia_pkg::ALL_ONES64, 1);
    send_item(wia_pkg::FN_SUB, 1, 1, 0, 5, 1, 64'h1_0000);
    send_item(wia_pkg::FN_SUB, 3, 0, 0, 0, wia_pkg::ALL_ONES64, 0);
    send_item(wia_pkg::FN_NEG, 2, 1, 64'h8000_0000, 3, 0, 0);
    send_item(wia_pkg::FN_NEG, 3, 0, 0, wia_pkg::ALL_ONES64, wia_pkg::ALL_ONES64,
              wia_pkg::ALL_ONES64);
    send_item(wia_pkg::FN_MUL, 0, 0, 64'hFF, 2, 64'hFF, 2);
    send_item(wia_pkg::FN_MUL, 3, 0, wia_pkg::ALL_ONES64, wia_pkg::ALL_ONES64,
              wia_pkg::ALL_ONES64, wia_pkg::ALL_ONES64);
    send_item(wia_pkg::FN_MUL, 3, 1, wia_pkg::NEG_LIMIT64, 0, wia_pkg::ALL_ONES64, 0);
    send_item(wia_pkg::FN_MUL, 3, 1, wia_pkg::NEG_LIMIT64, 1, wia_pkg::NEG_LIMIT64, 1);
    send_item(wia_pkg::FN_MUL, 0, 1, 64'h7E, 4, 64'h80, 3);
    send_item(wia_pkg::FN_UDIV, 0, 0, 100, 10, 0, 5);
    send_item(wia_pkg::FN_UDIV, 1, 0, 100, 10, 64'hFFFF, 1);
    send_item(wia_pkg::FN_UDIV, 0, 0, 64'hF0, 4, 64'h81, 2);
    send_item(wia_pkg::FN_UDIV, 2, 1, 100, 10, 3, 1);
    send_item(wia_pkg::FN_UDIV, 3, 0, wia_pkg::ALL_ONES64, 0, 1, 0);
    send_item(wia_pkg::FN_SDIV, 0, 1, 64'h80, 0, 64'hFF, 0);
    send_item(wia_pkg::FN_SDIV, 0, 1, 64'h80, 0, 64'hFE, 0);
    send_item(wia_pkg::FN_SDIV, 3, 1, wia_pkg::NEG_LIMIT64, 5, wia_pkg::ALL_ONES64, 2);
    send_item(wia_pkg::FN_SDIV, 2, 0, 10, 0, 3, 0);
    send_item(wia_pkg::FN_SDIV, 1, 1, 64'h7FFF, 64'h10, 64'hFFF0, 3);
    send_item(wia_pkg::FN_SDIV, 3, 1, 64'h7F, 64'hFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'h5);
    send_item(3'd6, 1, 0, 1, 1, 1, 1);
    send_item(3'd7, 3, 1, wia_pkg::ALL_ONES64, wia_pkg::ALL_ONES64,
              wia_pkg::ALL_ONES64, wia_pkg::ALL_ONES64);
    // Pause until the pipe has handed back every result
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (140) send_random();
    end
    recv_stall_pct = 0;
    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

>>> wrapped_interval_arith_unit_top.f
+incdir+src
src/wia_pkg.sv
src/wia_div_chain.sv
src/wrapped_interval_arith_unit_top.sv
src/wia_chk.sv
tb/tb_wrapped_interval_arith_unit_top.sv
